>>> rtl/core/delsrch_pkg.sv
// shared types and codes for the double-ended list with search
package delsrch_pkg;

	localparam int DATA_W = 32;
	localparam int POS_W  = 4;

	localparam logic signed [DATA_W-1:0] EMPTY_DATA = -32'sd1;

	typedef enum logic [1:0] {
		ACT_PUSH_FRONT = 2'd0,
		ACT_PUSH_BACK  = 2'd1,
		ACT_POP_FRONT  = 2'd2,
		ACT_SEARCH     = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE   = 2'd0,
		S_POP    = 2'd1,
		S_SEARCH = 2'd2,
		S_RESP   = 2'd3
	} state_t;

	typedef struct packed {
		status_t                   status;
		logic signed [DATA_W-1:0]  data;
		logic                      found;
		logic        [POS_W-1:0]   position;
	} res_t;

endpackage

>>> rtl/core/delsrch_req_if.sv
// request channel: action and value with valid/ready
interface delsrch_req_if;
	logic                                  valid;
	logic                                  ready;
	logic [1:0]                            action;
	logic signed [delsrch_pkg::DATA_W-1:0] value;

	modport source (output valid, output action, output value, input ready);
	modport sink (input valid, input action, input value, output ready);
endinterface

>>> rtl/core/delsrch_rsp_if.sv
// response channel: status, data, found and position with valid/ready
interface delsrch_rsp_if;
	logic                                  valid;
	logic                                  ready;
	logic [1:0]                            status;
	logic signed [delsrch_pkg::DATA_W-1:0] data;
	logic                                  found;
	logic [delsrch_pkg::POS_W-1:0]         position;

	modport source (output valid, output status, output data, output found,
		output position, input ready);
	modport sink (input valid, input status, input data, input found,
		input position, output ready);
endinterface

>>> rtl/core/delsrch_mem.sv
// entry store: one write port, one read port with registered data
module delsrch_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [AW-1:0]                         waddr,
	input  logic signed [delsrch_pkg::DATA_W-1:0] wdata,
	input  logic                                  re,
	input  logic [AW-1:0]                         raddr,
	output logic signed [delsrch_pkg::DATA_W-1:0] rdata
);
	import delsrch_pkg::*;

	logic signed [DATA_W-1:0] mem_q [DEPTH];
	logic signed [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/core/delsrch_ctrl.sv
// sequencer: ring pointers, pop read and one-entry-per-cycle search compare
module delsrch_ctrl #(
	parameter int CAPACITY = 16
) (
	input  logic                                               clk,
	input  logic                                               arst_n,
	input  logic                                               req_valid,
	output logic                                               req_ready,
	input  delsrch_pkg::action_t                               req_action,
	input  logic signed [delsrch_pkg::DATA_W-1:0]              req_value,
	output logic                                               mem_we,
	output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] mem_waddr,
	output logic signed [delsrch_pkg::DATA_W-1:0]              mem_wdata,
	output logic                                               mem_re,
	output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] mem_raddr,
	input  logic signed [delsrch_pkg::DATA_W-1:0]              mem_rdata,
	output logic                                               res_vld,
	input  logic                                               res_rdy,
	output delsrch_pkg::res_t                                  res
);
	import delsrch_pkg::*;

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [IW-1:0] LAST  = IW'(CAPACITY - 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
	localparam logic [CW:0]   CAP_W = (CW+1)'(CAPACITY);

	state_t                   state_q, state_d;
	logic [IW-1:0]            front_q;
	logic [CW-1:0]            count_q;
	logic signed [DATA_W-1:0] key_q;
	logic [CW-1:0]            iss_idx_q;
	logic [IW-1:0]            rd_ptr_q;
	logic                     cmp_vld_q;
	logic [CW-1:0]            cmp_idx_q;
	res_t                     res_q;

	logic          accept;
	logic          full;
	logic          empty;
	logic [IW-1:0] front_dec;
	logic [IW-1:0] front_inc;
	logic [IW-1:0] rd_ptr_inc;
	logic [CW:0]   back_sum;
	logic [CW:0]   back_wrap;
	logic [IW-1:0] back_pos;
	logic          issue;
	logic          hit;

	assign accept     = req_valid && req_ready;
	assign full       = (count_q == CAP_C);
	assign empty      = (count_q == '0);
	assign front_dec  = (front_q == '0) ? LAST : front_q - 1'b1;
	assign front_inc  = (front_q == LAST) ? '0 : front_q + 1'b1;
	assign rd_ptr_inc = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
	assign back_sum   = (CW+1)'(front_q) + (CW+1)'(count_q);
	// sum stays below twice the capacity, so one subtract wraps it
	assign back_wrap  = (back_sum >= CAP_W) ? back_sum - CAP_W : back_sum;
	assign back_pos   = back_wrap[IW-1:0];
	assign issue      = (state_q == S_SEARCH) && (iss_idx_q < count_q);
	// read data is registered, so it arrives in the cycle after its address was issued
	assign hit        = cmp_vld_q && (mem_rdata == key_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req_action)
						ACT_POP_FRONT: state_d = empty ? S_RESP : S_POP;
						ACT_SEARCH:    state_d = empty ? S_RESP : S_SEARCH;
						default:       state_d = S_RESP;
					endcase
				end
			end
			S_POP: state_d = S_RESP;
			S_SEARCH: begin
				if (hit || (cmp_vld_q && !issue)) begin
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (res_rdy) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		req_ready = (state_q == S_IDLE);
		mem_we    = 1'b0;
		mem_waddr = front_dec;
		mem_wdata = req_value;
		mem_re    = 1'b0;
		mem_raddr = front_q;
		res_vld   = (state_q == S_RESP);
		res       = res_q;
		case (state_q)
			S_IDLE: begin
				if (accept && !full) begin
					if (req_action == ACT_PUSH_FRONT) begin
						mem_we = 1'b1;
					end else if (req_action == ACT_PUSH_BACK) begin
						mem_we    = 1'b1;
						mem_waddr = back_pos;
					end
				end
				if (accept && !empty && (req_action == ACT_POP_FRONT)) begin
					mem_re = 1'b1;
				end
			end
			S_SEARCH: begin
				mem_re    = issue;
				mem_raddr = rd_ptr_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			front_q   <= '0;
			count_q   <= '0;
			cmp_vld_q <= 1'b0;
			iss_idx_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (!full && (req_action == ACT_PUSH_FRONT)) begin
							front_q <= front_dec;
							count_q <= count_q + 1'b1;
						end else if (!full && (req_action == ACT_PUSH_BACK)) begin
							count_q <= count_q + 1'b1;
						end
						cmp_vld_q <= 1'b0;
						iss_idx_q <= '0;
					end
				end
				S_POP: begin
					front_q <= front_inc;
					count_q <= count_q - 1'b1;
				end
				S_SEARCH: begin
					cmp_vld_q <= issue;
					if (issue) begin
						iss_idx_q <= iss_idx_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					res_q.status   <= ST_DONE;
					res_q.data     <= '0;
					res_q.found    <= 1'b0;
					res_q.position <= '0;
					key_q          <= req_value;
					rd_ptr_q       <= front_q;
					case (req_action)
						ACT_POP_FRONT: begin
							if (empty) begin
								res_q.status <= ST_EMPTY;
								res_q.data   <= EMPTY_DATA;
							end
						end
						ACT_SEARCH: begin
						end
						default: begin
							if (full) begin
								res_q.status <= ST_FULL;
							end
						end
					endcase
				end
			end
			S_POP: res_q.data <= mem_rdata;
			S_SEARCH: begin
				cmp_idx_q <= iss_idx_q;
				if (issue) begin
					rd_ptr_q <= rd_ptr_inc;
				end
				if (hit) begin
					res_q.found    <= 1'b1;
					res_q.position <= POS_W'(cmp_idx_q);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

>>> rtl/core/double_ended_list_with_search.sv
// top level of the double-ended list with search: sequencer, store, output register
//
//  channel  dir  fields                           accepted when
//  req      in   action, value                    req.valid && req.ready
//  rsp      out  status, data, found, position    rsp.valid && rsp.ready
//
// one request at a time; req.ready is high only while the sequencer is idle
// push goes from idle straight to the response state, pop passes through a read state
// and search through a compare state that stops at the first hit or the last entry; pop
// or search on an empty list go straight to the response; the single read port of the store sets one compare per cycle
// reset clears front index and count; the store itself is not cleared
// a finished response waits in the output register while the next request is taken
module double_ended_list_with_search #(
	parameter int CAPACITY = 16
) (
	input logic          clk,
	input logic          arst_n,
	delsrch_req_if.sink  req,
	delsrch_rsp_if.source rsp
);
	import delsrch_pkg::*;

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	logic                     mem_we;
	logic [IW-1:0]            mem_waddr;
	logic signed [DATA_W-1:0] mem_wdata;
	logic                     mem_re;
	logic [IW-1:0]            mem_raddr;
	logic signed [DATA_W-1:0] mem_rdata;
	logic                     res_vld;
	logic                     res_rdy;
	res_t                     res;
	logic                     rsp_vld_q;
	res_t                     rsp_q;

	delsrch_ctrl #(
		.CAPACITY (CAPACITY)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_ready  (req.ready),
		.req_action (action_t'(req.action)),
		.req_value  (req.value),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata),
		.res_vld    (res_vld),
		.res_rdy    (res_rdy),
		.res        (res)
	);

	delsrch_mem #(
		.DEPTH (CAPACITY),
		.AW    (IW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign res_rdy = !rsp_vld_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (res_vld && res_rdy) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_vld && res_rdy) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid    = rsp_vld_q;
	assign rsp.status   = rsp_q.status;
	assign rsp.data     = rsp_q.data;
	assign rsp.found    = rsp_q.found;
	assign rsp.position = rsp_q.position;

endmodule

>>> tb/tb_double_ended_list_with_search.sv
// testbench for the double-ended list with search: directed, random and backpressure tests
module tb_double_ended_list_with_search;
	timeunit 1ns;
	timeprecision 1ps;

	import delsrch_pkg::*;

	localparam int CAP            = 16;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LONG_HOLD      = 300;
	localparam int SETTLE_CYCLES  = 30;

	logic clk;
	logic arst_n;

	delsrch_req_if req_ch ();
	delsrch_rsp_if rsp_ch ();

	double_ended_list_with_search #(.CAPACITY(CAP)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// shadow copy of the list contents
	logic signed [DATA_W-1:0] m_words [CAP];
	logic [3:0]               m_front;
	logic [4:0]               m_count;

	res_t awaited_replies [$];
	int   fault_count;
	int   idle_cycles;
	int   long_hold_cycles;
	bit   tx_idle_en;
	bit   rx_idle_en;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// computes the reply of one request and updates the shadow list
	function automatic res_t list_op_outcome(action_t op, logic signed [DATA_W-1:0] word);
		res_t       r;
		logic [3:0] slot;
		r.status   = ST_DONE;
		r.data     = '0;
		r.found    = 1'b0;
		r.position = '0;
		case (op)
			ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
				if (m_count >= CAP) begin
					r.status = ST_FULL;
				end else if (op == ACT_PUSH_FRONT) begin
					m_front = m_front - 4'd1;
					m_words[m_front] = word;
					m_count = m_count + 5'd1;
				end else begin
					slot = m_front + m_count[3:0];
					m_words[slot] = word;
					m_count = m_count + 5'd1;
				end
			end
			ACT_POP_FRONT: begin
				if (m_count == 0) begin
					r.status = ST_EMPTY;
					r.data   = EMPTY_DATA;
				end else begin
					r.data  = m_words[m_front];
					m_front = m_front + 4'd1;
					m_count = m_count - 5'd1;
				end
			end
			default: begin
				for (int i = 0; i < m_count; i++) begin
					slot = m_front + 4'(i);
					if (!r.found && m_words[slot] == word) begin
						r.found    = 1'b1;
						r.position = 4'(i);
					end
				end
			end
		endcase
		return r;
	endfunction

	// mostly small repeating words so searches hit, sometimes extremes or full random
	function automatic logic signed [DATA_W-1:0] word_pick();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 6)
			return $urandom_range(0, 7);
		if (roll == 6) begin
			case ($urandom_range(0, 3))
				0: return 32'sh8000_0000;
				1: return 32'sh7FFF_FFFF;
				2: return -32'sd1;
				default: return 32'sd0;
			endcase
		end
		return $urandom;
	endfunction

	// key that is usually held in the list
	function automatic logic signed [DATA_W-1:0] search_key();
		logic [3:0] slot;
		if (m_count != 0 && $urandom_range(0, 2) != 0) begin
			slot = m_front + 4'($urandom_range(0, m_count - 1));
			return m_words[slot];
		end
		return word_pick();
	endfunction

	task automatic send_request(action_t op, logic signed [DATA_W-1:0] word);
		if (tx_idle_en && $urandom_range(0, 4) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		req_ch.valid  <= 1'b1;
		req_ch.action <= op;
		req_ch.value  <= word;
		do @(posedge clk); while (!req_ch.ready);
		awaited_replies.push_back(list_op_outcome(op, word));
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (awaited_replies.size() != 0) @(posedge clk);
	endtask

	task automatic test_empty_store();
		send_request(ACT_POP_FRONT, 32'sd5);
		send_request(ACT_SEARCH, 32'sd0);
	endtask

	task automatic test_extreme_words();
		send_request(ACT_PUSH_BACK, 32'sh7FFF_FFFF);
		send_request(ACT_PUSH_FRONT, 32'sh8000_0000);
		send_request(ACT_PUSH_BACK, -32'sd1);
		send_request(ACT_PUSH_FRONT, 32'sd0);
		send_request(ACT_SEARCH, 32'sd0);
		send_request(ACT_SEARCH, 32'sh8000_0000);
		send_request(ACT_SEARCH, 32'sh7FFF_FFFF);
		send_request(ACT_SEARCH, -32'sd1);
		send_request(ACT_SEARCH, 32'sh5555_AAAA);
		repeat (5) send_request(ACT_POP_FRONT, -32'sd1);
	endtask

	// fill to capacity with a duplicate inside, hit the full case, search the far end
	task automatic test_full_store();
		logic signed [DATA_W-1:0] back_word;
		logic signed [DATA_W-1:0] word;
		back_word = '0;
		for (int i = 0; i < CAP; i++) begin
			word = (i == 5 || i == 12) ? 32'sh0BAD_F00D : $urandom;
			if (i % 2 == 1) begin
				send_request(ACT_PUSH_FRONT, word);
			end else begin
				send_request(ACT_PUSH_BACK, word);
				back_word = word;
			end
		end
		send_request(ACT_PUSH_FRONT, 32'sd1);
		send_request(ACT_PUSH_BACK, 32'sd2);
		send_request(ACT_SEARCH, back_word);
		send_request(ACT_SEARCH, 32'sh0BAD_F00D);
		repeat (CAP + 1) send_request(ACT_POP_FRONT, $urandom);
	endtask

	// random traffic drifting between filling and draining phases
	task automatic test_random_mix(int n_items);
		int      run_left;
		int      roll;
		bit      fill_bias;
		action_t op;
		run_left  = 0;
		fill_bias = 1'b0;
		for (int k = 0; k < n_items; k++) begin
			if (run_left == 0) begin
				fill_bias = ~fill_bias;
				run_left  = $urandom_range(20, 60);
			end
			run_left--;
			roll = $urandom_range(0, 99);
			if (roll < 25)
				op = ACT_SEARCH;
			else if (roll < (fill_bias ? 80 : 45))
				op = $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
			else
				op = ACT_POP_FRONT;
			send_request(op, op == ACT_SEARCH ? search_key() : word_pick());
		end
	endtask

	// receiver holds off while requests keep coming, then the sender waits for all replies
	task automatic test_backpressure();
		tx_idle_en = 1'b0;
		long_hold_cycles = LONG_HOLD;
		for (int k = 0; k < 12; k++) begin
			send_request(k % 3 == 2 ? ACT_SEARCH : ACT_PUSH_BACK, word_pick());
		end
		wait_drained();
		tx_idle_en = 1'b1;
	endtask

	task automatic test_full_rate(int n_items);
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		test_random_mix(n_items);
	endtask

	// reply checker
	always @(posedge clk) begin
		res_t exp_r;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (awaited_replies.size() == 0) begin
				if (fault_count < 10)
					$display("reply with no request pending: status %0d data %0d",
						rsp_ch.status, rsp_ch.data);
				fault_count++;
			end else begin
				exp_r = awaited_replies.pop_front();
				if (rsp_ch.status !== exp_r.status || rsp_ch.data !== exp_r.data ||
					rsp_ch.found !== exp_r.found || rsp_ch.position !== exp_r.position) begin
					if (fault_count < 10)
						$display("reply mismatch: status %0d/%0d data %0d/%0d found %0d/%0d pos %0d/%0d (exp/got)",
							exp_r.status, rsp_ch.status, exp_r.data, rsp_ch.data,
							exp_r.found, rsp_ch.found, exp_r.position, rsp_ch.position);
					fault_count++;
				end
			end
		end
	end

	// reply ready with random stall bursts and an occasional long hold
	initial begin
		int hold_left;
		hold_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_cycles > 0) begin
				hold_left = long_hold_cycles;
				long_hold_cycles = 0;
			end
			if (!arst_n) begin
				rsp_ch.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
				hold_left = $urandom_range(1, 19) - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles with no request or reply moving
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		fault_count      = 0;
		idle_cycles      = 0;
		long_hold_cycles = 0;
		tx_idle_en       = 1'b1;
		rx_idle_en       = 1'b1;
		m_front          = '0;
		m_count          = '0;
		for (int i = 0; i < CAP; i++) m_words[i] = '0;
		arst_n        <= 1'b0;
		req_ch.valid  <= 1'b0;
		req_ch.action <= ACT_PUSH_FRONT;
		req_ch.value  <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_store();
		test_extreme_words();
		test_full_store();
		test_random_mix(1200);
		test_backpressure();
		test_full_rate(300);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fault_count == 0 && awaited_replies.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> files.f
rtl/core/delsrch_pkg.sv
rtl/core/delsrch_req_if.sv
rtl/core/delsrch_rsp_if.sv
rtl/core/delsrch_mem.sv
rtl/core/delsrch_ctrl.sv
rtl/core/double_ended_list_with_search.sv
tb/tb_double_ended_list_with_search.sv
